[rtl/tkh_pkg.sv]
// Shared constants for the top-k heavy hitter heap.
package tkh_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_BITS_DEF    = 32;
	localparam int CNT_W           = 32;
	localparam int KCFG_W          = 5;
	localparam int KCFG_RESET      = 16;

	localparam logic CMD_OBSERVE = 1'b0;
	localparam logic CMD_DRAIN   = 1'b1;

endpackage

[rtl/tkh_front.sv]
// Front end: takes commands and holds them in a two-entry queue for the back end.
module tkh_front #(
	parameter int KEY_BITS = tkh_pkg::KEY_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    cmd,
	input  logic [31:0]             key,
	input  logic [tkh_pkg::CNT_W-1:0] total_count,
	output logic                    q_valid,
	input  logic                    q_pop,
	output logic                    q_cmd,
	output logic [KEY_BITS-1:0]     q_key,
	output logic [tkh_pkg::CNT_W-1:0] q_count
);
	import tkh_pkg::*;

	logic [1:0]          cnt_q;
	logic                rd_q, wr_q;
	logic                cmd_q [2];
	logic [KEY_BITS-1:0] key_q [2];
	logic [CNT_W-1:0]    tc_q  [2];
	logic                push;
	logic [KEY_BITS-1:0] key_in;

	// keys narrower or wider than the port: low bits kept, zero extended
	always_comb begin
		key_in = '0;
		for (int b = 0; b < KEY_BITS; b++) begin
			if (b < 32) key_in[b] = key[b];
		end
	end

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = cmd_q[rd_q];
	assign q_key   = key_q[rd_q];
	assign q_count = tc_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_q] <= cmd;
			key_q[wr_q] <= key_in;
			tc_q[wr_q]  <= total_count;
		end
	end

endmodule

[rtl/tkh_back.sv]
// Back end: heap storage, key search, sift-down, rebuild and heap-sort drain.
module tkh_back #(
	parameter int MAX_ENTRIES = tkh_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = tkh_pkg::KEY_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [tkh_pkg::KCFG_W-1:0] k_cfg,
	input  logic                      q_valid,
	output logic                      q_pop,
	input  logic                      q_cmd,
	input  logic [KEY_BITS-1:0]       q_key,
	input  logic [tkh_pkg::CNT_W-1:0] q_count,
	output logic                      done,
	output logic [31:0]               out_key,
	output logic [tkh_pkg::CNT_W-1:0] out_count,
	output logic                      is_empty,
	output logic                      last
);
	import tkh_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = 2 * IW + 3;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SEARCH = 9'b000000010,
		ST_DECIDE = 9'b000000100,
		ST_SIFT   = 9'b000001000,
		ST_REBLD  = 9'b000010000,
		ST_SORT   = 9'b000100000,
		ST_EMIT   = 9'b001000000,
		ST_EMPTY  = 9'b010000000,
		ST_INC    = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [KEY_BITS-1:0] key_mem [MAX_ENTRIES];
	logic [CNT_W-1:0]    cnt_mem [MAX_ENTRIES];
	logic [NW-1:0]       fill_q, lim_q, idx_q;
	logic [IW-1:0]       pos_q, rb_q;
	logic                ret_q; // sift caller: 0 rebuild/observe, 1 sort
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    tc_q;
	logic [NW-1:0]       cap;

	always_comb begin
		cap = NW'(k_cfg);
		if (k_cfg == '0) cap = NW'(1);
		if ({{(32-KCFG_W){1'b0}}, k_cfg} > 32'(MAX_ENTRIES)) cap = NW'(MAX_ENTRIES);
	end

	// one sift step at pos_q within lim_q
	logic [CW-1:0] lc, rc;
	logic [IW-1:0] sel;
	logic          do_swap;
	always_comb begin
		lc  = {{(CW-IW){1'b0}}, pos_q} * CW'(2) + CW'(1);
		rc  = lc + CW'(1);
		sel = pos_q;
		if (lc < CW'(lim_q) && cnt_mem[lc[IW-1:0]] < cnt_mem[pos_q]) sel = lc[IW-1:0];
		if (rc < CW'(lim_q) && cnt_mem[rc[IW-1:0]] < cnt_mem[sel]) sel = rc[IW-1:0];
		do_swap = (sel != pos_q);
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	logic [IW-1:0] ix;
	assign ix = idx_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			done     <= 1'b0;
			idx_q    <= '0;
			lim_q    <= '0;
			pos_q    <= '0;
			rb_q     <= '0;
			ret_q    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						idx_q <= '0;
						lim_q <= fill_q;
						if (q_cmd == CMD_DRAIN) begin
							if (fill_q == '0) state_q <= ST_EMPTY;
							else begin
								idx_q   <= fill_q;
								state_q <= ST_SORT;
							end
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (idx_q == fill_q) state_q <= ST_DECIDE;
					else if (key_mem[ix] == key_q) begin
						pos_q   <= ix;
						state_q <= ST_INC;
					end else idx_q <= idx_q + NW'(1);
				end
				ST_INC: begin
					ret_q   <= 1'b0;
					rb_q    <= '0;
					state_q <= ST_SIFT;
				end
				ST_DECIDE: begin
					if (fill_q < cap) begin
						fill_q <= fill_q + NW'(1);
						lim_q  <= fill_q + NW'(1);
						rb_q   <= (fill_q >= NW'(1)) ? IW'((fill_q - NW'(1)) >> 1) : '0;
						pos_q  <= (fill_q >= NW'(1)) ? IW'((fill_q - NW'(1)) >> 1) : '0;
						ret_q  <= 1'b0;
						state_q <= ST_SIFT;
					end else if (fill_q != '0 && tc_q > cnt_mem[0]) begin
						pos_q   <= '0;
						rb_q    <= '0;
						ret_q   <= 1'b0;
						state_q <= ST_SIFT;
					end else state_q <= ST_IDLE;
				end
				ST_SIFT: begin
					if (do_swap) pos_q <= sel;
					else if (ret_q) state_q <= ST_SORT;
					else if (rb_q != '0) begin
						rb_q  <= rb_q - IW'(1);
						pos_q <= rb_q - IW'(1);
					end else state_q <= ST_IDLE;
				end
				ST_SORT: begin
					if (idx_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q   <= idx_q - NW'(1);
						lim_q   <= idx_q - NW'(1);
						pos_q   <= '0;
						ret_q   <= 1'b1;
						state_q <= ST_SIFT;
					end
				end
				ST_EMIT: begin
					done     <= 1'b1;
					idx_q    <= idx_q + NW'(1);
					if (idx_q + NW'(1) == fill_q) begin
						fill_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_EMPTY: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			key_q <= q_key;
			tc_q  <= q_count;
		end
		case (state_q)
			ST_INC: if (cnt_mem[pos_q] != '1) cnt_mem[pos_q] <= cnt_mem[pos_q] + CNT_W'(1);
			ST_DECIDE: begin
				if (fill_q < cap) begin
					key_mem[fill_q[IW-1:0]] <= key_q;
					cnt_mem[fill_q[IW-1:0]] <= tc_q;
				end else if (fill_q != '0 && tc_q > cnt_mem[0]) begin
					key_mem[0] <= key_q;
					cnt_mem[0] <= tc_q;
				end
			end
			ST_SIFT: if (do_swap) begin
				key_mem[sel]   <= key_mem[pos_q];
				cnt_mem[sel]   <= cnt_mem[pos_q];
				key_mem[pos_q] <= key_mem[sel];
				cnt_mem[pos_q] <= cnt_mem[sel];
			end
			// root swapped with itself on the last step: nothing to move
			ST_SORT: if (idx_q > NW'(1)) begin
				key_mem[0]              <= key_mem[IW'(idx_q - NW'(1))];
				cnt_mem[0]              <= cnt_mem[IW'(idx_q - NW'(1))];
				key_mem[IW'(idx_q - NW'(1))] <= key_mem[0];
				cnt_mem[IW'(idx_q - NW'(1))] <= cnt_mem[0];
			end
			default: ;
		endcase
		if (state_q == ST_EMIT) begin
			for (int b = 0; b < 32; b++) out_key[b] <= (b < KEY_BITS) ? key_mem[ix][b % KEY_BITS] : 1'b0;
			out_count <= cnt_mem[ix];
			is_empty  <= 1'b0;
			last      <= (idx_q + NW'(1) == fill_q);
		end else if (state_q == ST_EMPTY) begin
			out_key   <= '0;
			out_count <= '0;
			is_empty  <= 1'b1;
			last      <= 1'b1;
		end
	end

endmodule

[rtl/top_k_frequency_min_heap.sv]
// Top level of the top-k heavy hitter min-heap.
// Usage:
//   Commands enter on start/busy: a command is taken at a clock edge with
//   start high and busy low; cmd 0 observes key with its running
//   total_count, cmd 1 drains. A two-beat queue decouples intake from the
//   heap engine, so busy rises only when two commands wait.
//   The capacity register is written on cfg_valid/cfg_ready (always ready);
//   write it only while the block is idle.
//   Results appear for one cycle with done high; the receiver cannot stall.
// Operation:
//   Observe searches the held keys in order, then sifts the heap; an append
//   rebuilds the whole heap. Drain heap-sorts the entries, then emits one
//   result per cycle, last on the final one. An empty drain gives one result
//   with is_empty set. The back end takes a new command only after the last
//   one is through.
// Reset: arst_n clears the queue, the fill count and the capacity to 16.
module top_k_frequency_min_heap #(
	parameter int MAX_ENTRIES = tkh_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = tkh_pkg::KEY_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [31:0]                key,
	input  logic [tkh_pkg::CNT_W-1:0]  total_count,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tkh_pkg::KCFG_W-1:0] cfg_data,
	output logic                       done,
	output logic [31:0]                out_key,
	output logic [tkh_pkg::CNT_W-1:0]  out_count,
	output logic                       is_empty,
	output logic                       last
);
	import tkh_pkg::*;

	logic [KCFG_W-1:0]   k_q;
	logic                q_valid, q_pop, q_cmd;
	logic [KEY_BITS-1:0] q_key;
	logic [CNT_W-1:0]    q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) k_q <= KCFG_W'(KCFG_RESET);
		else if (cfg_valid) k_q <= cfg_data;
	end

	tkh_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk, .arst_n, .start, .busy, .cmd, .key, .total_count,
		.q_valid, .q_pop, .q_cmd, .q_key, .q_count
	);

	tkh_back #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
		.clk, .arst_n, .k_cfg(k_q), .q_valid, .q_pop, .q_cmd, .q_key, .q_count,
		.done, .out_key, .out_count, .is_empty, .last
	);

endmodule
